// ===== rtl/lsu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the level-set upwind update block.
// Depends on nothing; every other file in rtl/ except lsu_ram imports it.
package lsu_pkg;

	localparam int MAX_CELLS_DEF   = 64;
	localparam int LEVEL_WIDTH_DEF = 24;
	localparam int FRAC_BITS       = 12;
	localparam int VEL_W           = 16;
	localparam int TS_W            = 16;
	localparam int STEP_W          = 8;

	// register indexes on the config port
	localparam logic CFG_TIME_STEP  = 1'b0;
	localparam logic CFG_STEP_COUNT = 1'b1;

	// width of the integer square root for a given level width
	function automatic int root_w(input int lw);
		return lw + 1;
	endfunction

	// width of the update numerator time_step * |v| * root
	function automatic int num_w(input int lw);
		return TS_W + VEL_W + root_w(lw);
	endfunction

	// datapath operations issued by the controller
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_PAD,
		OP_FWD,
		OP_BWD,
		OP_CAP_L,
		OP_CAP_C,
		OP_CAP_R,
		OP_MAG,
		OP_SQ_A,
		OP_SQ_B,
		OP_RT_STEP,
		OP_MUL1,
		OP_MUL2,
		OP_DV_STEP,
		OP_WR_NEXT,
		OP_EMIT,
		OP_CLEAR
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   first;     // first cell of a distance sweep
		logic   cell_we;   // cell store write enable
		logic   rd_bank;   // level bank read: 1 = bank B
		logic   wr_bank;   // level bank written by OP_WR_NEXT
		logic   emit_last; // emitted beat is the final cell
	} cmd_t;

	typedef struct packed {
		logic peak_zero;
		logic vel_zero;
		logic out_free;
	} stat_t;

endpackage

// ===== rtl/level_set_upwind_update_1d.sv =====
`timescale 1ns / 1ps
// Top level of the 1-D level-set upwind update: config registers,
// controller and datapath. Depends on lsu_pkg, lsu_ctrl, lsu_dp, lsu_ram.
//
// Cells load one per cycle (in_stall low) until the beat marked last_cell.
// The block then stalls its input while it pads both ends of the row, runs
// the two distance sweeps over m = n+2 cells, and runs step_count update
// passes of m cells each. A cell with zero velocity keeps its level; any
// other runs the bit-serial square root (LEVEL_WIDTH+1 steps) and the
// bit-serial divider (LEVEL_WIDTH+33 steps). Results then leave one at a
// time: each cell is read, then loaded into the output register once that
// register is free. If every velocity is zero the sweeps and passes are skipped.
// Configuration is taken at any time on cfg_valid (cfg_ready is always high)
// but must only change while the block is idle.
module level_set_upwind_update_1d #(
	parameter int MAX_CELLS   = lsu_pkg::MAX_CELLS_DEF,
	parameter int LEVEL_WIDTH = lsu_pkg::LEVEL_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             cell_solid,
	input  logic signed [lsu_pkg::VEL_W-1:0] cell_velocity,
	input  logic                             last_cell,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             new_solid,
	output logic                             last_out,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_index,
	input  logic [lsu_pkg::TS_W-1:0]         cfg_data
);

	import lsu_pkg::*;

	localparam int AW = $clog2(MAX_CELLS + 2);

	logic [TS_W-1:0]   time_step_q;
	logic [STEP_W-1:0] step_count_q;
	cmd_t              cmd;
	stat_t             stat;
	logic [AW-1:0]     raddr, waddr, row_last;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q  <= TS_W'(4096);
			step_count_q <= STEP_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TIME_STEP:  time_step_q  <= cfg_data;
				CFG_STEP_COUNT: step_count_q <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	lsu_ctrl #(.MAX_CELLS(MAX_CELLS), .LEVEL_WIDTH(LEVEL_WIDTH)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .last_cell(last_cell),
		.step_count(step_count_q), .stat(stat), .in_stall(in_stall), .cmd(cmd),
		.raddr(raddr), .waddr(waddr), .row_last(row_last)
	);

	lsu_dp #(.MAX_CELLS(MAX_CELLS), .LEVEL_WIDTH(LEVEL_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.raddr(raddr), .waddr(waddr), .row_last(row_last),
		.time_step(time_step_q), .cell_solid(cell_solid),
		.cell_velocity(cell_velocity), .new_solid(new_solid),
		.last_out(last_out), .out_valid(out_valid), .out_stall(out_stall)
	);

endmodule

// ===== rtl/lsu_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 66
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/lsu_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the level-set update: load, padding, distance sweeps,
// update passes and emission. Depends on lsu_pkg.
module lsu_ctrl #(
	parameter int MAX_CELLS   = lsu_pkg::MAX_CELLS_DEF,
	parameter int LEVEL_WIDTH = lsu_pkg::LEVEL_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             last_cell,
	input  logic [lsu_pkg::STEP_W-1:0]       step_count,
	input  lsu_pkg::stat_t                   stat,
	output logic                             in_stall,
	output lsu_pkg::cmd_t                    cmd,
	output logic [$clog2(MAX_CELLS+2)-1:0]   raddr,
	output logic [$clog2(MAX_CELLS+2)-1:0]   waddr,
	output logic [$clog2(MAX_CELLS+2)-1:0]   row_last
);

	import lsu_pkg::*;

	localparam int AW = $clog2(MAX_CELLS + 2);
	localparam int CW = $clog2(MAX_CELLS + 1);
	localparam int RW = root_w(LEVEL_WIDTH);
	localparam int NW = num_w(LEVEL_WIDTH);
	localparam int IW = $clog2(NW);

	typedef enum logic [4:0] {
		S_LOAD, S_PAD0, S_PADN,
		S_FWD_RD, S_FWD_WR, S_BWD_RD, S_BWD_WR,
		S_P_RL, S_P_RC, S_P_RR, S_P_CAP, S_P_MAG,
		S_P_SQA, S_P_SQB, S_P_RT, S_P_MUL1, S_P_MUL2, S_P_DV, S_P_WR,
		S_E_RD, S_E_LD, S_DONE
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     cnt_q;
	logic [CW-1:0]     n_q;
	logic [STEP_W-1:0] pass_q;
	logic [IW-1:0]     iter_q;
	logic              bank_q;
	logic              room;
	logic              at_end;

	assign row_last = AW'(n_q) + AW'(1);
	assign room     = n_q < CW'(MAX_CELLS);
	assign at_end   = cnt_q == row_last;
	assign in_stall = state_q != S_LOAD;

	// command decode
	always_comb begin
		cmd           = '0;
		cmd.op        = OP_NONE;
		cmd.rd_bank   = bank_q;
		cmd.wr_bank   = ~bank_q;
		cmd.emit_last = cnt_q == AW'(n_q);
		raddr         = cnt_q;
		waddr         = cnt_q;
		unique case (state_q)
			S_LOAD: begin
				waddr = AW'(n_q) + AW'(1);
				if (in_valid) begin
					cmd.op      = OP_LOAD;
					cmd.cell_we = room;
				end
			end
			S_PAD0: begin
				cmd.op      = OP_PAD;
				cmd.cell_we = 1'b1;
				waddr       = '0;
			end
			S_PADN: begin
				cmd.op      = OP_PAD;
				cmd.cell_we = 1'b1;
				waddr       = row_last;
			end
			S_FWD_WR: begin
				cmd.op    = OP_FWD;
				cmd.first = cnt_q == '0;
			end
			S_BWD_RD: cmd.rd_bank = 1'b1;
			S_BWD_WR: begin
				cmd.op      = OP_BWD;
				cmd.first   = at_end;
				cmd.rd_bank = 1'b1;
			end
			S_P_RL:   raddr = (cnt_q == '0) ? row_last : cnt_q - AW'(1);
			S_P_RC:   cmd.op = OP_CAP_L;
			S_P_RR: begin
				cmd.op = OP_CAP_C;
				raddr  = at_end ? '0 : cnt_q + AW'(1);
			end
			S_P_CAP:  cmd.op = OP_CAP_R;
			S_P_MAG:  cmd.op = OP_MAG;
			S_P_SQA:  cmd.op = OP_SQ_A;
			S_P_SQB:  cmd.op = OP_SQ_B;
			S_P_RT:   cmd.op = OP_RT_STEP;
			S_P_MUL1: cmd.op = OP_MUL1;
			S_P_MUL2: cmd.op = OP_MUL2;
			S_P_DV:   cmd.op = OP_DV_STEP;
			S_P_WR:   cmd.op = OP_WR_NEXT;
			S_E_LD: begin
				if (stat.out_free) begin
					cmd.op = OP_EMIT;
				end
			end
			S_DONE:   cmd.op = OP_CLEAR;
			default:  cmd.op = OP_NONE;
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q   <= '0;
			n_q     <= '0;
			pass_q  <= '0;
			iter_q  <= '0;
			bank_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						if (room) begin
							n_q <= n_q + CW'(1);
						end
						if (last_cell) begin
							state_q <= S_PAD0;
						end
					end
				end
				S_PAD0: state_q <= S_PADN;
				S_PADN: begin
					if (stat.peak_zero) begin
						cnt_q   <= AW'(1);
						state_q <= S_E_RD;
					end else begin
						cnt_q   <= '0;
						state_q <= S_FWD_RD;
					end
				end
				S_FWD_RD: state_q <= S_FWD_WR;
				S_FWD_WR: begin
					if (at_end) begin
						state_q <= S_BWD_RD;
					end else begin
						cnt_q   <= cnt_q + AW'(1);
						state_q <= S_FWD_RD;
					end
				end
				S_BWD_RD: state_q <= S_BWD_WR;
				S_BWD_WR: begin
					if (cnt_q == '0) begin
						bank_q <= 1'b0;
						pass_q <= '0;
						if (step_count == '0) begin
							cnt_q   <= AW'(1);
							state_q <= S_E_RD;
						end else begin
							state_q <= S_P_RL;
						end
					end else begin
						cnt_q   <= cnt_q - AW'(1);
						state_q <= S_BWD_RD;
					end
				end
				S_P_RL:  state_q <= S_P_RC;
				S_P_RC:  state_q <= S_P_RR;
				S_P_RR:  state_q <= S_P_CAP;
				S_P_CAP: state_q <= S_P_MAG;
				S_P_MAG: state_q <= stat.vel_zero ? S_P_WR : S_P_SQA;
				S_P_SQA: state_q <= S_P_SQB;
				S_P_SQB: begin
					iter_q  <= '0;
					state_q <= S_P_RT;
				end
				S_P_RT: begin
					if (iter_q == IW'(RW - 1)) begin
						state_q <= S_P_MUL1;
					end else begin
						iter_q <= iter_q + IW'(1);
					end
				end
				S_P_MUL1: state_q <= S_P_MUL2;
				S_P_MUL2: begin
					iter_q  <= '0;
					state_q <= S_P_DV;
				end
				S_P_DV: begin
					if (iter_q == IW'(NW - 1)) begin
						state_q <= S_P_WR;
					end else begin
						iter_q <= iter_q + IW'(1);
					end
				end
				S_P_WR: begin
					if (at_end) begin
						bank_q <= ~bank_q;
						pass_q <= pass_q + STEP_W'(1);
						if (pass_q + STEP_W'(1) == step_count) begin
							cnt_q   <= AW'(1);
							state_q <= S_E_RD;
						end else begin
							cnt_q   <= '0;
							state_q <= S_P_RL;
						end
					end else begin
						cnt_q   <= cnt_q + AW'(1);
						state_q <= S_P_RL;
					end
				end
				S_E_RD: state_q <= S_E_LD;
				S_E_LD: begin
					if (stat.out_free) begin
						if (cnt_q == AW'(n_q)) begin
							state_q <= S_DONE;
						end else begin
							cnt_q   <= cnt_q + AW'(1);
							state_q <= S_E_RD;
						end
					end
				end
				S_DONE: begin
					n_q     <= '0;
					state_q <= S_LOAD;
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule

// ===== rtl/lsu_dp.sv =====
`timescale 1ns / 1ps
// Datapath: cell and level stores, distance sweep, upwind arithmetic with
// bit-serial square root and divider, output register. Depends on lsu_pkg, lsu_ram.
module lsu_dp #(
	parameter int MAX_CELLS   = lsu_pkg::MAX_CELLS_DEF,
	parameter int LEVEL_WIDTH = lsu_pkg::LEVEL_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lsu_pkg::cmd_t                       cmd,
	output lsu_pkg::stat_t                      stat,
	input  logic [$clog2(MAX_CELLS+2)-1:0]      raddr,
	input  logic [$clog2(MAX_CELLS+2)-1:0]      waddr,
	input  logic [$clog2(MAX_CELLS+2)-1:0]      row_last,
	input  logic [lsu_pkg::TS_W-1:0]            time_step,
	input  logic                                cell_solid,
	input  logic signed [lsu_pkg::VEL_W-1:0]    cell_velocity,
	output logic                                new_solid,
	output logic                                last_out,
	output logic                                out_valid,
	input  logic                                out_stall
);

	import lsu_pkg::*;

	localparam int ROW  = MAX_CELLS + 2;
	localparam int AW   = $clog2(ROW);
	localparam int DW   = $clog2(MAX_CELLS + 4);
	localparam int LW   = LEVEL_WIDTH;
	localparam int RW   = root_w(LW);
	localparam int SW   = 2 * LW;
	localparam int RADW = 2 * RW;
	localparam int NW   = num_w(LW);
	localparam int DNW  = VEL_W + FRAC_BITS;
	localparam int EW   = (DW + 14 > LW + 1) ? DW + 14 : LW + 1;
	localparam int QW   = NW + 2;
	localparam logic [63:0] NORM_CAP = 64'h7FFF_FFFF;
	localparam logic signed [EW-1:0] EHI = {{(EW-LW+1){1'b0}}, {(LW-1){1'b1}}};
	localparam logic signed [EW-1:0] ELO = {{(EW-LW+1){1'b1}}, {(LW-1){1'b0}}};
	localparam logic signed [QW-1:0] QHI = {{(QW-LW+1){1'b0}}, {(LW-1){1'b1}}};
	localparam logic signed [QW-1:0] QLO = {{(QW-LW+1){1'b1}}, {(LW-1){1'b0}}};
	localparam logic [EW-1:0] HALF = EW'(1 << (FRAC_BITS - 1));

	// stores
	logic [VEL_W:0]  cell_wdata, cell_rd;
	logic            we_a, we_b;
	logic [LW-1:0]   lvl_wdata, rd_a, rd_b, lvl_rd;

	assign cell_wdata = (cmd.op == OP_PAD) ? '0 : {cell_solid, cell_velocity};

	lsu_ram #(.WIDTH(VEL_W + 1), .DEPTH(ROW)) u_cell (
		.clk(clk), .we(cmd.cell_we), .waddr(waddr), .wdata(cell_wdata),
		.raddr(raddr), .rdata(cell_rd)
	);
	lsu_ram #(.WIDTH(LW), .DEPTH(ROW)) u_lvl_a (
		.clk(clk), .we(we_a), .waddr(waddr), .wdata(lvl_wdata),
		.raddr(raddr), .rdata(rd_a)
	);
	lsu_ram #(.WIDTH(LW), .DEPTH(ROW)) u_lvl_b (
		.clk(clk), .we(we_b), .waddr(waddr), .wdata(lvl_wdata),
		.raddr(raddr), .rdata(rd_b)
	);

	assign lvl_rd = cmd.rd_bank ? rd_b : rd_a;
	assign we_a   = (cmd.op == OP_BWD) || (cmd.op == OP_WR_NEXT && !cmd.wr_bank);
	assign we_b   = (cmd.op == OP_FWD) || (cmd.op == OP_WR_NEXT && cmd.wr_bank);

	// registers
	logic [VEL_W-1:0]        peak_q;
	logic                    nb_solid_q, have_q;
	logic [DW-1:0]           dist_q;
	logic signed [LW-1:0]    left_q, ctr_q, right_q;
	logic signed [VEL_W-1:0] vel_q;
	logic [LW-1:0]           a_q, b_q;
	logic [SW-1:0]           sq_q;
	logic [RADW-1:0]         rad_q;
	logic [RW+1:0]           rem_q;
	logic [RW-1:0]           root_q;
	logic [TS_W+VEL_W-1:0]   tv_q;
	logic [NW-1:0]           divsh_q, quo_q;
	logic [DNW:0]            drem_q;
	logic                    out_valid_q, new_solid_q, last_q;

	// distance sweep step: run length to the nearest cell of the other kind
	logic          s_cur, differ, have_n;
	logic [DW-1:0] inf_d, dist_n, best;
	logic signed [EW-1:0] init_mag, init_val, init_sat;

	assign s_cur  = cell_rd[VEL_W];
	assign inf_d  = DW'(row_last) + DW'(2);
	assign differ = !cmd.first && (s_cur != nb_solid_q);
	assign have_n = differ || (have_q && !cmd.first);
	assign dist_n = differ ? DW'(1) : (have_n ? dist_q + DW'(1) : inf_d);
	assign best   = (lvl_rd[DW-1:0] < dist_n) ? lvl_rd[DW-1:0] : dist_n;
	assign init_mag = $signed(({{(EW-DW){1'b0}}, best} << FRAC_BITS) - HALF);
	assign init_val = s_cur ? -init_mag : init_mag;
	assign init_sat = (init_val > EHI) ? EHI : ((init_val < ELO) ? ELO : init_val);

	// one-sided differences and their clipped parts
	logic signed [LW:0] dp, dm, ndp, ndm;
	logic [LW-1:0]      a_n, b_n, a_c, b_c;

	assign dp  = {right_q[LW-1], right_q} - {ctr_q[LW-1], ctr_q};
	assign dm  = {ctr_q[LW-1], ctr_q} - {left_q[LW-1], left_q};
	assign ndp = -dp;
	assign ndm = -dm;
	always_comb begin
		if (vel_q[VEL_W-1]) begin
			a_n = dm[LW] ? ndm[LW-1:0] : '0;
			b_n = (!dp[LW] && dp != '0) ? dp[LW-1:0] : '0;
		end else begin
			a_n = (!dm[LW] && dm != '0) ? dm[LW-1:0] : '0;
			b_n = dp[LW] ? ndp[LW-1:0] : '0;
		end
	end
	assign a_c = (64'(a_n) > NORM_CAP) ? LW'(NORM_CAP) : a_n;
	assign b_c = (64'(b_n) > NORM_CAP) ? LW'(NORM_CAP) : b_n;

	// arithmetic steps
	logic [SW-1:0]         sq_b;
	logic [RW+1:0]         rt_rem_n, rt_trial;
	logic [VEL_W-1:0]      vabs, vabs_in;
	logic [TS_W+VEL_W-1:0] tv_n;
	logic [NW-1:0]         num_n;
	logic [DNW:0]          dv_rem_n, den;
	logic signed [QW-1:0]  ctr_x, quo_x, nx, nx_sat;

	assign sq_b     = b_q * b_q;
	assign rt_rem_n = {rem_q[RW-1:0], rad_q[RADW-1 -: 2]};
	assign rt_trial = {root_q, 2'b01};
	assign vabs     = vel_q[VEL_W-1] ? VEL_W'(-vel_q) : vel_q;
	assign vabs_in  = cell_velocity[VEL_W-1] ? VEL_W'(-cell_velocity) : cell_velocity;
	assign tv_n     = time_step * vabs;
	assign num_n    = tv_q * root_q;
	assign den      = {1'b0, peak_q, {FRAC_BITS{1'b0}}};
	assign dv_rem_n = {drem_q[DNW-1:0], divsh_q[NW-1]};
	assign ctr_x    = {{(QW-LW){ctr_q[LW-1]}}, ctr_q};
	assign quo_x    = $signed({2'b00, quo_q});
	assign nx       = vel_q[VEL_W-1] ? ctr_x + quo_x : ctr_x - quo_x;
	assign nx_sat   = (nx > QHI) ? QHI : ((nx < QLO) ? QLO : nx);

	// level write data
	always_comb begin
		case (cmd.op)
			OP_FWD:     lvl_wdata = LW'(dist_n);
			OP_BWD:     lvl_wdata = init_sat[LW-1:0];
			default:    lvl_wdata = (vel_q == '0) ? ctr_q : nx_sat[LW-1:0];
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_LOAD && cmd.cell_we && vabs_in > peak_q) begin
				peak_q <= vabs_in;
			end else if (cmd.op == OP_CLEAR) begin
				peak_q <= '0;
			end
			if (cmd.op == OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_FWD, OP_BWD: begin
				nb_solid_q <= s_cur;
				dist_q     <= dist_n;
				have_q     <= have_n;
			end
			OP_CAP_L: left_q <= lvl_rd;
			OP_CAP_C: begin
				ctr_q <= lvl_rd;
				vel_q <= cell_rd[VEL_W-1:0];
			end
			OP_CAP_R: right_q <= lvl_rd;
			OP_MAG: begin
				a_q <= a_c;
				b_q <= b_c;
			end
			OP_SQ_A: sq_q <= a_q * a_q;
			OP_SQ_B: begin
				rad_q  <= RADW'(sq_q) + RADW'(sq_b);
				rem_q  <= '0;
				root_q <= '0;
			end
			OP_RT_STEP: begin
				rad_q <= rad_q << 2;
				if (rt_rem_n >= rt_trial) begin
					rem_q  <= rt_rem_n - rt_trial;
					root_q <= {root_q[RW-2:0], 1'b1};
				end else begin
					rem_q  <= rt_rem_n;
					root_q <= {root_q[RW-2:0], 1'b0};
				end
			end
			OP_MUL1: tv_q <= tv_n;
			OP_MUL2: begin
				divsh_q <= num_n;
				drem_q  <= '0;
				quo_q   <= '0;
			end
			OP_DV_STEP: begin
				divsh_q <= divsh_q << 1;
				if (dv_rem_n >= den) begin
					drem_q <= dv_rem_n - den;
					quo_q  <= {quo_q[NW-2:0], 1'b1};
				end else begin
					drem_q <= dv_rem_n;
					quo_q  <= {quo_q[NW-2:0], 1'b0};
				end
			end
			OP_EMIT: begin
				new_solid_q <= (peak_q == '0) ? cell_rd[VEL_W] : lvl_rd[LW-1];
				last_q      <= cmd.emit_last;
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign new_solid     = new_solid_q;
	assign last_out      = last_q;
	assign stat.peak_zero = peak_q == '0;
	assign stat.vel_zero  = vel_q == '0;
	assign stat.out_free  = !out_valid_q || !out_stall;

endmodule

// ===== bench/level_set_upwind_update_1d_checker.sv =====
`timescale 1ns / 1ps
// Checker for level_set_upwind_update_1d: watches the cell, result and config
// channels, predicts each emitted cell and compares. Depends on lsu_pkg.
module level_set_upwind_update_1d_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        cell_solid,
	input  logic signed [lsu_pkg::VEL_W-1:0] cell_velocity,
	input  logic        last_cell,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        new_solid,
	input  logic        last_out,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [lsu_pkg::TS_W-1:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	localparam int CELLS = lsu_pkg::MAX_CELLS_DEF;
	localparam int ROW = CELLS + 2;
	localparam int LW = lsu_pkg::LEVEL_WIDTH_DEF;

	typedef struct {
		bit solid;
		bit last;
	} cell_result_t;

	cell_result_t emitted_cells[$];

	bit [15:0] dt_q12;
	bit [7:0]  pass_total;
	bit        row_solid[ROW];
	int        row_vel[ROW];
	longint    level[ROW];
	int        peak_mag;
	int        n_loaded;

	assign pending = emitted_cells.size();

	function automatic longint clamp_level(input longint x);
		longint hi;
		hi = (longint'(1) <<< (LW - 1)) - 1;
		if (x > hi) return hi;
		if (x < -hi - 1) return -hi - 1;
		return x;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// magnitude of the negative or positive part of a difference, capped
	function automatic longint unsigned side_mag(input longint d, input bit neg);
		longint unsigned mag;
		if (neg) mag = (d < 0) ? longint'(-d) : 0;
		else mag = (d > 0) ? longint'(d) : 0;
		return (mag > 64'd2147483647) ? 64'd2147483647 : mag;
	endfunction

	// signed distance start values over the padded row
	function automatic void build_distance(input int m);
		int best, d;
		longint v;
		for (int i = 0; i < m; i++) begin
			best = m + 1;
			for (int j = 0; j < m; j++) begin
				d = (i > j) ? i - j : j - i;
				if (row_solid[j] != row_solid[i] && d < best) best = d;
			end
			v = longint'(best) * 4096 - 2048;
			level[i] = clamp_level(row_solid[i] ? -v : v);
		end
	endfunction

	// one periodic upwind pass
	function automatic void upwind_pass(input int m);
		longint nxt[ROW];
		longint lv, dp, dm;
		longint unsigned a, b, u, num, q, den, vmag;
		int lft, rgt, v;
		den = longint'(peak_mag) * 4096;
		for (int j = 0; j < m; j++) begin
			lft = (j == 0) ? m - 1 : j - 1;
			rgt = (j + 1 >= m) ? 0 : j + 1;
			lv = level[j];
			dp = level[rgt] - lv;
			dm = lv - level[lft];
			v = row_vel[j];
			if (v == 0) begin
				nxt[j] = lv;
			end else begin
				a = side_mag(dm, v < 0);
				b = side_mag(dp, v > 0);
				u = int_sqrt(a * a + b * b);
				vmag = (v < 0) ? -v : v;
				num = longint'(dt_q12) * u * vmag;
				q = num / den;
				nxt[j] = clamp_level(v > 0 ? lv - longint'(q) : lv + longint'(q));
			end
		end
		for (int j = 0; j < m; j++) level[j] = nxt[j];
	endfunction

	// store one accepted cell; on the last one predict the whole row
	function automatic void take_cell(input bit s, input int v, input bit lst);
		int n, mag;
		cell_result_t r;
		if (n_loaded < CELLS) begin
			mag = (v < 0) ? -v : v;
			row_solid[n_loaded + 1] = s;
			row_vel[n_loaded + 1] = v;
			if (mag > peak_mag) peak_mag = mag;
			n_loaded++;
		end
		if (!lst) return;
		n = n_loaded;
		row_solid[0] = 0;
		row_solid[n + 1] = 0;
		row_vel[0] = 0;
		row_vel[n + 1] = 0;
		if (peak_mag != 0) begin
			build_distance(n + 2);
			for (int k = 0; k < pass_total; k++) upwind_pass(n + 2);
		end
		for (int i = 0; i < n; i++) begin
			r.solid = (peak_mag == 0) ? row_solid[i + 1] : (level[i + 1] < 0);
			r.last = (i + 1 == n);
			emitted_cells.push_back(r);
		end
		n_loaded = 0;
		peak_mag = 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cell_result_t want;
		if (!arst_n) begin
			dt_q12 = 16'd4096;
			pass_total = 8'd1;
			peak_mag = 0;
			n_loaded = 0;
			fail_count = 0;
			emitted_cells.delete();
		end else begin
			// compare before predicting: a result never needs this edge's cell
			if (out_valid && !out_stall) begin
				if (emitted_cells.size() == 0) begin
					$error("unexpected result beat: new_solid=%0b last_out=%0b",
						new_solid, last_out);
					fail_count++;
				end else begin
					want = emitted_cells.pop_front();
					if (new_solid !== want.solid) begin
						$error("new_solid: expected %0b, got %0b", want.solid, new_solid);
						fail_count++;
					end
					if (last_out !== want.last) begin
						$error("last_out: expected %0b, got %0b", want.last, last_out);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				take_cell(cell_solid, int'(cell_velocity), last_cell);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == lsu_pkg::CFG_TIME_STEP) dt_q12 = cfg_data;
				else pass_total = cfg_data[7:0];
			end
		end
	end

endmodule

// ===== bench/level_set_upwind_update_1d_tb.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for level_set_upwind_update_1d: drives cell rows and
// register writes. Depends on lsu_pkg, the block and the checker module.
module level_set_upwind_update_1d_tb;
	localparam int WATCHDOG = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic cell_solid = 1'b0;
	logic signed [lsu_pkg::VEL_W-1:0] cell_velocity = '0;
	logic last_cell = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic new_solid;
	logic last_out;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = lsu_pkg::CFG_TIME_STEP;
	logic [lsu_pkg::TS_W-1:0] cfg_data = '0;

	int  fail_count;
	int  pending;
	int  idle_cycles = 0;
	int  stall_left = 0;
	bit  quiet = 1'b0;
	int  cells_sent = 0;

	level_set_upwind_update_1d DUT (.*);

	level_set_upwind_update_1d_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver stalls in bursts, none in the closing part
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			if (stall_left == 0) out_stall <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(1, 13);
		end
	end

	// no beat on any channel for too long ends the run
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG) begin
			$display("end of test: mismatches");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// one cell beat, with an optional gap before it
	task automatic send_cell(input bit s, input logic signed [15:0] v, input bit lst);
		bit taken;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cell_solid <= s;
		cell_velocity <= v;
		last_cell <= lst;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		cells_sent++;
		if (lst) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// hold off until every predicted cell has left, plus drain time
	task automatic wait_drained();
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] value);
		bit taken;
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_velocity();
		int k;
		k = $urandom_range(0, 9);
		if (k < 2) return 16'sd0;
		if (k == 2) return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
		return 16'($urandom);
	endfunction

	// a random row of n cells; all_zero gives a row with no motion
	task automatic send_row(input int n, input bit all_zero);
		for (int i = 0; i < n; i++)
			send_cell(1'($urandom_range(0, 1)), all_zero ? 16'sd0 : pick_velocity(),
				i == n - 1);
	endtask

	initial begin
		int n, steps;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single cell, extremes of velocity, zero velocity row
		send_cell(1'b1, 16'sh7FFF, 1'b1);
		send_cell(1'b1, 16'sh8000, 1'b0);
		send_cell(1'b0, 16'sd0, 1'b0);
		send_cell(1'b1, 16'sd1, 1'b1);
		send_cell(1'b1, 16'sd0, 1'b0);
		send_cell(1'b0, 16'sd0, 1'b0);
		send_cell(1'b1, 16'sd0, 1'b1);
		write_reg(lsu_pkg::CFG_STEP_COUNT, 16'd0);
		send_cell(1'b0, 16'sh4000, 1'b0);
		send_cell(1'b1, -16'sh1000, 1'b1);
		write_reg(lsu_pkg::CFG_STEP_COUNT, 16'd255);
		write_reg(lsu_pkg::CFG_TIME_STEP, 16'hFFFF);
		send_cell(1'b0, 16'sh7FFF, 1'b0);
		send_cell(1'b1, -16'sh0800, 1'b0);
		send_cell(1'b0, 16'sh0010, 1'b1);
		write_reg(lsu_pkg::CFG_TIME_STEP, 16'd0);
		send_cell(1'b1, 16'sh2000, 1'b0);
		send_cell(1'b0, -16'sh2000, 1'b1);

		// overlong row: cells past MAX_CELLS are dropped
		write_reg(lsu_pkg::CFG_STEP_COUNT, 16'd1);
		write_reg(lsu_pkg::CFG_TIME_STEP, 16'd4096);
		send_row(lsu_pkg::MAX_CELLS_DEF + 3, 1'b0);

		// random rows, mostly short, with register changes between them
		while (cells_sent < 110) begin
			if (cells_sent > 95) quiet = 1'b1;
			if ($urandom_range(0, 2) == 0) begin
				steps = ($urandom_range(0, 5) == 0) ? 255 : $urandom_range(1, 6);
				write_reg(lsu_pkg::CFG_STEP_COUNT, 16'(steps));
				write_reg(lsu_pkg::CFG_TIME_STEP, ($urandom_range(0, 4) == 0) ?
					16'hFFFF : 16'($urandom));
			end
			n = (steps == 255) ? $urandom_range(1, 3) : $urandom_range(1, 8);
			send_row(n, $urandom_range(0, 7) == 0);
		end

		wait_drained();
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/lsu_pkg.sv
rtl/lsu_ram.sv
rtl/lsu_ctrl.sv
rtl/lsu_dp.sv
rtl/level_set_upwind_update_1d.sv
bench/level_set_upwind_update_1d_checker.sv
bench/level_set_upwind_update_1d_tb.sv
